FILE: rtl/core/str_pkg.sv
// shared types and constants for the segment tree range sum block
package str_pkg;

	localparam int DATA_W = 64;

	// func field codes
	localparam logic FUNC_SET   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_RD,
		ST_SET_WR,
		ST_QRY_LO,
		ST_QRY_HI,
		ST_QRY_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic start_set;
		logic start_qry;
		logic sib_rd;
		logic par_wr;
		logic lo_rd;
		logic hi_step;
		logic hi_rd;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic at_root;
		logic lo_odd;
		logic hi_odd;
		logic lo_lt_hi;
		logic out_full;
	} status_t;

endpackage

FILE: rtl/core/str_if.sv
// request and result channel interfaces
interface str_req_if #(
	parameter int POS_W = 10
);
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic [POS_W-1:0]         position;
	logic [POS_W:0]           range_end;
	logic signed [63:0]       value;

	modport source (output valid, func, position, range_end, value, input ready);
	modport sink   (input valid, func, position, range_end, value, output ready);
endinterface

interface str_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] range_sum;

	modport source (output valid, range_sum, input ready);
	modport sink   (input valid, range_sum, output ready);
endinterface

FILE: rtl/core/str_ctrl.sv
// sequencer for clear pass, leaf update walk and range query walk
module str_ctrl
	import str_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_func,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_SET) begin
						cmd.start_set = 1'b1;
						state_nxt     = ST_SET_RD;
					end else begin
						cmd.start_qry = 1'b1;
						state_nxt     = ST_QRY_LO;
					end
				end
			end
			ST_SET_RD: begin
				if (status.at_root) begin
					state_nxt = ST_IDLE;
				end else begin
					cmd.sib_rd = 1'b1;
					state_nxt  = ST_SET_WR;
				end
			end
			ST_SET_WR: begin
				cmd.par_wr = 1'b1;
				state_nxt  = ST_SET_RD;
			end
			ST_QRY_LO: begin
				if (status.lo_lt_hi) begin
					cmd.lo_rd = status.lo_odd;
					state_nxt = ST_QRY_HI;
				end else begin
					state_nxt = ST_QRY_FIN;
				end
			end
			ST_QRY_HI: begin
				cmd.hi_step = 1'b1;
				cmd.hi_rd   = status.hi_odd;
				state_nxt   = ST_QRY_LO;
			end
			ST_QRY_FIN: begin
				if (!status.out_full) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

FILE: rtl/core/str_datapath.sv
// tree memory, walk registers, accumulator and result register
module str_datapath
	import str_pkg::*;
#(
	parameter int LEAVES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output status_t                       status,
	input  logic [$clog2(LEAVES)-1:0]     position,
	input  logic [$clog2(LEAVES):0]       range_end,
	input  logic signed [DATA_W-1:0]      value,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [DATA_W-1:0]      out_sum
);

	localparam int POS_W  = $clog2(LEAVES);
	localparam int END_W  = POS_W + 1;
	localparam int NODE_W = POS_W + 1;
	localparam int HI_W   = POS_W + 2;
	localparam int DEPTH  = 2 * LEAVES;

	localparam logic [END_W-1:0]  LEAF_E = END_W'(LEAVES);
	localparam logic [NODE_W-1:0] LEAF_N = NODE_W'(LEAVES);
	localparam logic [HI_W-1:0]   LEAF_H = HI_W'(LEAVES);

	// heap order, node k at slot k, root at 1, slot 0 unused
	logic [DATA_W-1:0] tree_q [DEPTH];

	logic [NODE_W-1:0] clr_addr_q;
	logic [NODE_W-1:0] k_q;
	logic [HI_W-1:0]   lo_q;
	logic [HI_W-1:0]   hi_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rd_pend_s1;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_sum_q;

	logic              mem_we;
	logic [NODE_W-1:0] mem_addr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] acc_sum;
	logic [END_W-1:0]  end_clamp;
	logic [HI_W-1:0]   hi_dec;
	logic [NODE_W-1:0] leaf_node;

	assign acc_sum   = acc_q + rdata_q;
	assign end_clamp = (range_end > LEAF_E) ? LEAF_E : range_end;
	assign hi_dec    = hi_q - HI_W'(1);
	assign leaf_node = NODE_W'(position) + LEAF_N;

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = k_q ^ NODE_W'(1);
		mem_wdata = acc_sum;
		if (cmd.clr_wr) begin
			mem_we    = 1'b1;
			mem_addr  = clr_addr_q;
			mem_wdata = '0;
		end else if (cmd.start_set) begin
			mem_we    = 1'b1;
			mem_addr  = leaf_node;
			mem_wdata = value;
		end else if (cmd.par_wr) begin
			mem_we    = 1'b1;
			mem_addr  = k_q >> 1;
		end else if (cmd.lo_rd) begin
			mem_addr  = lo_q[NODE_W-1:0];
		end else if (cmd.hi_rd) begin
			mem_addr  = hi_dec[NODE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) tree_q[mem_addr] <= mem_wdata;
		rdata_q <= tree_q[mem_addr];
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.start_set) begin
			k_q <= leaf_node;
		end else if (cmd.par_wr) begin
			k_q <= k_q >> 1;
		end

		if (cmd.start_qry) begin
			lo_q <= HI_W'(position) + LEAF_H;
			hi_q <= HI_W'(end_clamp) + LEAF_H;
		end else if (cmd.lo_rd) begin
			lo_q <= lo_q + HI_W'(1);
		end else if (cmd.hi_step) begin
			lo_q <= lo_q >> 1;
			hi_q <= hi_q >> 1;
		end

		if (cmd.start_set) begin
			acc_q <= value;
		end else if (cmd.start_qry) begin
			acc_q <= '0;
		end else if (cmd.par_wr || rd_pend_s1) begin
			acc_q <= acc_sum;
		end

		if (cmd.out_load) out_sum_q <= acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_addr_q <= clr_addr_q + NODE_W'(1);
			rd_pend_s1 <= cmd.lo_rd || cmd.hi_rd;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.clr_last = (clr_addr_q == NODE_W'(DEPTH - 1));
	assign status.at_root  = (k_q == NODE_W'(1));
	assign status.lo_odd   = lo_q[0];
	assign status.hi_odd   = hi_q[0];
	assign status.lo_lt_hi = (lo_q < hi_q);
	assign status.out_full = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;

endmodule

FILE: rtl/core/segment_tree_range_sum.sv
// top level of the segment tree range sum block
//
//  channel | dir | payload                              | beat when
//  --------+-----+--------------------------------------+-------------------
//  req     | in  | func, position, range_end, value     | req.valid & ready
//  rsp     | out | range_sum (one per query, none/set)  | rsp.valid & ready
//
// set: the accept writes the leaf, then each level takes a sibling read and a
//   parent write, and a root check ends the walk before the next possible beat
// query: the accept loads the edges, then each tree level takes a low edge step
//   and a high edge step, over at most log2(LEAVES)+1 levels, then a last compare
//   and a finish state come before the next possible beat
// reset: a clearing pass zeroes the tree, with req.ready low until it ends
// stalls: a finished sum sits in the result register while the next item is
//   taken; a second sum waits in the finish state until that register frees
module segment_tree_range_sum
	import str_pkg::*;
#(
	parameter int LEAVES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	str_req_if.sink   req,
	str_rsp_if.source rsp
);

	cmd_t    cmd;
	status_t status;

	// sequencer: one item in flight, walks the tree level by level
	str_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// tree store, walk pointers, accumulator and output register
	str_datapath #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.position  (req.position),
		.range_end (req.range_end),
		.value     (req.value),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_sum   (rsp.range_sum)
	);

endmodule

FILE: rtl/core/str_checker.sv
// port level checks for the segment tree range sum block, with bind
module str_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] range_sum
);

	// a waiting result holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(range_sum))
		else $error("result changed or dropped while stalled");

	// one item at a time: no back to back acceptance
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in flight");

	// no query can finish in the cycle after an accept
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared too soon after a request beat");

	// a result is posted as the block returns to idle
	a_idle_on_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("result posted while block still busy");

endmodule

bind segment_tree_range_sum str_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.range_sum (rsp.range_sum)
);
